FILE: hw/rtl/trbs_pkg.sv
package trbs_pkg;

    localparam int RES_FRAC_BITS_DEF = 12;
    localparam int MAX_HALVINGS_DEF  = 40;

    // shared multiplier operand width (signed); holds the cubed log term
    localparam int MUL_W    = 38;
    localparam int LOG_FRAC = 24;
    localparam int INV_W    = 42;
    localparam int TK_W     = 24;

    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    localparam logic [63:0] COEF_A  = ((64'd11292 << 48) + 64'd5000000) / 64'd10000000;
    localparam logic [63:0] COEF_B  = ((64'd23410 << 40) + 64'd50000000) / 64'd100000000;
    localparam logic [63:0] COEF_C  = ((64'd87754 << 36) + 64'd122070312) / 64'd244140625;
    localparam logic [24:0] KELVIN_OFFSET = 25'd6992640;
    localparam logic [63:0] INV_NUMER = 64'd25600 << 48;

    typedef enum logic [1:0] {
        REG_LOW_BOUND  = 2'd0,
        REG_HIGH_BOUND = 2'd1,
        REG_TOLERANCE  = 2'd2
    } cfg_index_t;

    localparam int OUT_TDATA_W = 40;

endpackage

FILE: hw/rtl/thermistor_resistance_bisection_solver.sv
// Channel   | Direction | Signals                          | Contents
// s_*       | in        | s_tvalid s_tready s_tdata[15:0]  | target temperature request
// m_*       | out       | m_tvalid m_tready m_tdata[39:0]  | root, halvings, error flag
// cfg_*     | in        | cfg_valid cfg_ready index data   | bound and tolerance writes
//
// A request first forms the reciprocal of the Kelvin temperature with the
// bit-serial divider, then runs each log evaluation on the shared multiplier,
// where the 24 squarings dominate. A search of N halvings
// needs N+1 evaluations. s_tready is high only while the sequencer is idle.
// Reset clears the bounds to 1 ohm and 100000 ohm and the tolerance to 1 ohm.
// A finished result waits in the output register while the next request is taken.
module thermistor_resistance_bisection_solver #(
    parameter int RESISTANCE_FRAC_BITS = trbs_pkg::RES_FRAC_BITS_DEF,
    parameter int MAX_HALVINGS         = trbs_pkg::MAX_HALVINGS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] target_temperature
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [trbs_pkg::OUT_TDATA_W-1:0] m_tdata,
        // [31:0] root_resistance, [37:32] halvings, [38] input_error, [39] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int MW    = trbs_pkg::MUL_W;
    localparam int CNT_W = $clog2(MAX_HALVINGS + 1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_DIV, ST_CHECK, ST_EVAL, ST_NORM, ST_SQ_MUL, ST_SQ_UPD,
        ST_M_LN, ST_S_LN, ST_M_L2, ST_S_L2, ST_M_L3, ST_S_L3,
        ST_M_BL, ST_S_BL, ST_M_CL, ST_S_CL, ST_DONE
    } state_t;

    state_t state_reg;

    logic [31:0] low_bound_reg, high_bound_reg, tolerance_reg;
    logic [31:0] lo_reg, hi_reg, mid_reg, x_reg, y_reg;
    logic [CNT_W-1:0] count_reg;
    logic        err_reg, lo_done_reg, flo_neg_reg, flo_zero_reg;
    logic [trbs_pkg::TK_W-1:0] tk_reg;
    logic [24:0] rem_reg;
    logic [63:0] div_reg;
    logic [5:0]  step_reg;
    logic [4:0]  p_reg;
    logic [23:0] frac_reg;
    logic signed [MW-1:0] l_reg, l2_reg, l3_reg;
    logic signed [63:0] f_reg, prod_reg;

    logic signed [MW-1:0] mul_a, mul_b, lg;
    logic signed [2*MW-1:0] mul_p;
    logic signed [7:0]  expo;
    logic signed [24:0] t_ext, tk_full;
    logic signed [33:0] span, limit;
    logic [31:0] mid_new, sq_val, norm_x;
    logic [4:0]  sh;
    logic        norm_hit, search_on, fmid_neg, fmid_zero, go_low;
    logic [25:0] div_trial;
    logic signed [63:0] f_new;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign t_ext   = 25'(signed'(s_tdata));
    assign tk_full = (t_ext <<< 6) + (t_ext <<< 5) + (t_ext <<< 2)
                     + signed'(trbs_pkg::KELVIN_OFFSET);

    assign span      = signed'({2'b00, hi_reg}) - signed'({2'b00, lo_reg});
    assign limit     = signed'({1'b0, tolerance_reg, 1'b0});
    assign search_on = (span > limit) && (count_reg < CNT_W'(MAX_HALVINGS));
    assign mid_new   = 32'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);

    assign div_trial = {rem_reg, div_reg[63]};

    assign sh       = 5'd16 >> step_reg[2:0];
    assign norm_hit = ((x_reg >> (6'd32 - {1'b0, sh})) == 32'd0);
    assign norm_x   = norm_hit ? (x_reg << sh) : x_reg;

    assign sq_val = prod_reg[61:30];

    assign expo = signed'(8'(p_reg)) - signed'(8'(RESISTANCE_FRAC_BITS));
    assign lg   = signed'({{(MW - 32){expo[7]}}, expo, frac_reg});

    assign f_new     = f_reg + (prod_reg >>> 24);
    assign fmid_neg  = f_new[63];
    assign fmid_zero = (f_new == 64'sd0);
    // f(lo)*f(mid) <= 0: a zero on either side, or opposite signs
    assign go_low = flo_zero_reg || fmid_zero || (flo_neg_reg != fmid_neg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SQ_MUL:
            begin
                mul_a = signed'({{(MW - 32){1'b0}}, y_reg});
                mul_b = signed'({{(MW - 32){1'b0}}, y_reg});
            end
            ST_M_LN:
            begin
                mul_a = lg;
                mul_b = signed'(MW'(trbs_pkg::LN2_Q30));
            end
            ST_M_L2:
            begin
                mul_a = l_reg;
                mul_b = l_reg;
            end
            ST_M_L3:
            begin
                mul_a = l2_reg;
                mul_b = l_reg;
            end
            ST_M_BL:
            begin
                mul_a = signed'(MW'(trbs_pkg::COEF_B));
                mul_b = l_reg;
            end
            ST_M_CL:
            begin
                mul_a = signed'(MW'(trbs_pkg::COEF_C));
                mul_b = l3_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= signed'(mul_p[63:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_bound_reg  <= 32'd4096;
            high_bound_reg <= 32'd409600000;
            tolerance_reg  <= 32'd4096;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                trbs_pkg::REG_LOW_BOUND:  low_bound_reg  <= cfg_data;
                trbs_pkg::REG_HIGH_BOUND: high_bound_reg <= cfg_data;
                trbs_pkg::REG_TOLERANCE:  tolerance_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            m_tvalid  <= 1'b0;
        end
        else
        begin
            // in ST_DONE a taken result is replaced by the new one below
            if (m_tvalid && m_tready && state_reg != ST_DONE)
                m_tvalid <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        lo_reg      <= low_bound_reg;
                        hi_reg      <= high_bound_reg;
                        mid_reg     <= 32'(({1'b0, low_bound_reg} + {1'b0, high_bound_reg}) >> 1);
                        count_reg   <= '0;
                        err_reg     <= 1'b0;
                        lo_done_reg <= 1'b0;
                        tk_reg      <= tk_full[trbs_pkg::TK_W-1:0];
                        rem_reg     <= '0;
                        div_reg     <= trbs_pkg::INV_NUMER
                                       + 64'(tk_full[trbs_pkg::TK_W-1:1]);
                        step_reg    <= '0;
                        state_reg   <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    // restoring division, one quotient bit a cycle
                    if (div_trial >= {2'b00, tk_reg})
                    begin
                        rem_reg <= 25'(div_trial - {2'b00, tk_reg});
                        div_reg <= {div_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= div_trial[24:0];
                        div_reg <= {div_reg[62:0], 1'b0};
                    end
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd63)
                        state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    if (!search_on)
                        state_reg <= ST_DONE;
                    else if (!lo_done_reg)
                    begin
                        x_reg     <= lo_reg;
                        state_reg <= ST_EVAL;
                    end
                    else
                    begin
                        mid_reg   <= mid_new;
                        x_reg     <= mid_new;
                        count_reg <= count_reg + CNT_W'(1);
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL:
                begin
                    if (x_reg == 32'd0)
                    begin
                        err_reg <= 1'b1;
                        x_reg   <= 32'd1;
                    end
                    p_reg     <= 5'd31;
                    step_reg  <= '0;
                    state_reg <= ST_NORM;
                end
                ST_NORM:
                begin
                    // binary search for the top set bit: 16, 8, 4, 2, 1
                    x_reg <= norm_x;
                    if (norm_hit)
                        p_reg <= p_reg - sh;
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd4)
                    begin
                        y_reg     <= norm_x >> 1;
                        frac_reg  <= '0;
                        step_reg  <= '0;
                        state_reg <= ST_SQ_MUL;
                    end
                end
                ST_SQ_MUL:
                    state_reg <= ST_SQ_UPD;
                ST_SQ_UPD:
                begin
                    if (sq_val[31])
                    begin
                        y_reg    <= sq_val >> 1;
                        frac_reg <= {frac_reg[22:0], 1'b1};
                    end
                    else
                    begin
                        y_reg    <= sq_val;
                        frac_reg <= {frac_reg[22:0], 1'b0};
                    end
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'(trbs_pkg::LOG_FRAC - 1))
                        state_reg <= ST_M_LN;
                    else
                        state_reg <= ST_SQ_MUL;
                end
                ST_M_LN: state_reg <= ST_S_LN;
                ST_S_LN:
                begin
                    l_reg     <= MW'(prod_reg >>> 30);
                    state_reg <= ST_M_L2;
                end
                ST_M_L2: state_reg <= ST_S_L2;
                ST_S_L2:
                begin
                    l2_reg    <= MW'(prod_reg >>> 24);
                    state_reg <= ST_M_L3;
                end
                ST_M_L3: state_reg <= ST_S_L3;
                ST_S_L3:
                begin
                    l3_reg    <= MW'(prod_reg >>> 24);
                    state_reg <= ST_M_BL;
                end
                ST_M_BL: state_reg <= ST_S_BL;
                ST_S_BL:
                begin
                    f_reg <= signed'(trbs_pkg::COEF_A)
                             - signed'(64'(div_reg[trbs_pkg::INV_W-1:0]))
                             + (prod_reg >>> 16);
                    state_reg <= ST_M_CL;
                end
                ST_M_CL: state_reg <= ST_S_CL;
                ST_S_CL:
                begin
                    // keep f(lo) as sign flags; it moves only when lo does
                    if (!lo_done_reg)
                    begin
                        lo_done_reg  <= 1'b1;
                        flo_neg_reg  <= fmid_neg;
                        flo_zero_reg <= fmid_zero;
                    end
                    else if (go_low)
                        hi_reg <= mid_reg;
                    else
                    begin
                        lo_reg       <= mid_reg;
                        flo_neg_reg  <= fmid_neg;
                        flo_zero_reg <= fmid_zero;
                    end
                    state_reg <= ST_CHECK;
                end
                ST_DONE:
                begin
                    if (!m_tvalid || m_tready)
                    begin
                        m_tvalid  <= 1'b1;
                        m_tdata   <= {1'b0, err_reg, 6'(count_reg), mid_reg};
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: hw/rtl/trbs_checker.sv
module trbs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [trbs_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // busy right after a request is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("solver ready in the cycle after a request");

    // a result takes at least the divider time, never the next cycle
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result appeared right after a request");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or dropped");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[trbs_pkg::OUT_TDATA_W-1])
        else $error("result padding bit set");

endmodule

bind thermistor_resistance_bisection_solver trbs_checker u_trbs_checker (.*);
